>>> sv/srsc_pkg.sv
// ---------------------------------------------------------------------------
// srsc_pkg
// Shared constants, types and helper functions of the serial relay switch
// controller.
// ---------------------------------------------------------------------------
package srsc_pkg;

  // Sizes
  localparam int SRSC_NUM_SWITCHES = 11;
  localparam int FRAME_BYTES       = 16;
  localparam int POS_W             = 4;
  localparam int LEVEL_BITS        = 11;
  localparam int NUM_W             = 7;   // switch numbers up to 99
  localparam int QUEUE_DEPTH       = 2;
  localparam int MSG_BYTES         = 4;

  localparam logic [POS_W-1:0] FRAME_LAST = 4'd15;

  // ASCII characters
  localparam logic [7:0] CH_PCT  = 8'h25;  // '%'
  localparam logic [7:0] CH_AT   = 8'h40;  // '@'
  localparam logic [7:0] CH_G    = 8'h47;  // 'G'
  localparam logic [7:0] CH_R    = 8'h52;  // 'R'
  localparam logic [7:0] CH_E    = 8'h45;  // 'E'
  localparam logic [7:0] CH_X    = 8'h58;  // 'X'
  localparam logic [7:0] CH_L    = 8'h4C;  // 'L'
  localparam logic [7:0] CH_S    = 8'h53;  // 'S'
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE  = 8'h31;  // '1'
  localparam logic [7:0] CH_NINE = 8'h39;  // '9'

  // Work handed from the front end to the transmit side
  typedef struct packed {
    logic                           has_msg;
    logic [MSG_BYTES-1:0][7:0]      text;
    logic [LEVEL_BITS-1:0]          relays;
  } srsc_desc_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Two ASCII digits of a number below 100, tens in the upper byte
  function automatic logic [15:0] dec_ascii(input logic [NUM_W-1:0] num);
    logic [3:0]       tens;
    logic [NUM_W-1:0] ones;
    tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (num >= NUM_W'(k * 10)) tens = 4'(k);
    end
    ones = num - ({3'b000, tens} << 3) - ({3'b000, tens} << 1);
    return {CH_ZERO + {4'b0000, tens}, CH_ZERO + {4'b0000, ones[3:0]}};
  endfunction

endpackage

>>> sv/srsc_front.sv
// ---------------------------------------------------------------------------
// srsc_front
// Accepts serial bytes and switch scans, keeps the frame, lock, relay and
// pending-change state, and queues one message descriptor per transaction.
// ---------------------------------------------------------------------------
module srsc_front import srsc_pkg::*; #(
  parameter int NUM_SWITCHES = SRSC_NUM_SWITCHES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [LEVEL_BITS-1:0] switch_levels_i,
  output logic                  desc_valid_o,
  input  logic                  desc_ready_i,
  output srsc_desc_t            desc_o
);

  localparam int EXT_W = (NUM_SWITCHES > LEVEL_BITS) ? NUM_SWITCHES : LEVEL_BITS;

  logic [POS_W-1:0]        pos_q, pos_d;
  logic [NUM_SWITCHES-1:0] lock_q, lock_d;
  logic [NUM_SWITCHES-1:0] relay_q, relay_d;
  logic [NUM_SWITCHES-1:0] mark_q, mark_d;
  logic [7:0]              frame_q [FRAME_BYTES];

  logic                    accept;
  logic [EXT_W-1:0]        lv_ext, rel_ext;
  logic [NUM_SWITCHES-1:0] lv, hit, first, num_hot;
  logic [NUM_W-1:0]        scan_idx, frame_num;
  logic [3:0]              hi_dig, lo_dig;
  logic [15:0]             idx_ascii;
  logic                    frame_ok;

  assign accept       = in_valid_i & desc_ready_i;
  assign in_ready_o   = desc_ready_i;
  assign desc_valid_o = accept;

  // Scan: lowest unlocked switch whose level equals its pending mark
  assign lv_ext = EXT_W'(switch_levels_i);
  assign lv     = lv_ext[NUM_SWITCHES-1:0];
  assign hit    = ~lock_q & ~(lv ^ mark_q);
  assign first  = hit & (~hit + 1'b1);

  always_comb begin
    scan_idx = '0;
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      if (first[i]) scan_idx = scan_idx | NUM_W'(i + 1);
    end
  end

  assign idx_ascii = dec_ascii(scan_idx);

  // Frame: byte 0 is known to be '%' once the last byte arrives
  assign frame_ok = (frame_q[1] == CH_PCT) && (frame_q[14] == CH_AT) &&
                    (rx_byte_i == CH_AT);
  assign hi_dig   = frame_q[2][3:0] - CH_ZERO[3:0];
  assign lo_dig   = frame_q[3][3:0] - CH_ZERO[3:0];

  always_comb begin
    frame_num = '0;
    if (is_digit(frame_q[2])) begin
      if (is_digit(frame_q[3])) begin
        frame_num = ({3'b000, hi_dig} << 3) + ({3'b000, hi_dig} << 1) + {3'b000, lo_dig};
      end else begin
        frame_num = {3'b000, hi_dig};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SWITCHES; i++) begin
      num_hot[i] = (frame_num == NUM_W'(i + 1));
    end
  end

  // Next state and descriptor
  always_comb begin
    pos_d          = pos_q;
    lock_d         = lock_q;
    relay_d        = relay_q;
    mark_d         = mark_q;
    desc_o.has_msg = 1'b0;
    desc_o.text    = '0;
    if (opcode_i) begin
      if (|hit) begin
        mark_d         = (mark_q & ~first) | (~lv & first);
        relay_d        = (relay_q & ~first) | (lv & first);
        desc_o.has_msg = 1'b1;
        desc_o.text[0] = CH_R;
        desc_o.text[1] = (|(lv & first)) ? CH_ONE : CH_ZERO;
        desc_o.text[2] = idx_ascii[15:8];
        desc_o.text[3] = idx_ascii[7:0];
      end
    end else if ((pos_q == '0) && (rx_byte_i != CH_PCT)) begin
      pos_d          = '0;
      desc_o.has_msg = 1'b1;
      desc_o.text[0] = CH_E;
      desc_o.text[1] = CH_R;
      desc_o.text[2] = CH_R;
      desc_o.text[3] = CH_X;
    end else if (pos_q == FRAME_LAST) begin
      pos_d = '0;
      if (!frame_ok) begin
        desc_o.has_msg = 1'b1;
        desc_o.text[0] = CH_E;
        desc_o.text[1] = CH_R;
        desc_o.text[2] = CH_L;
        desc_o.text[3] = CH_S;
      end else begin
        lock_d  = (lock_q & ~num_hot) | (num_hot & {NUM_SWITCHES{frame_q[7] != CH_ZERO}});
        relay_d = (relay_q & ~num_hot) | (num_hot & {NUM_SWITCHES{frame_q[4][0]}});
        if (frame_q[8] == CH_ONE) begin
          desc_o.has_msg = 1'b1;
          desc_o.text[0] = CH_G;
          desc_o.text[1] = frame_q[4];
          desc_o.text[2] = frame_q[2];
          desc_o.text[3] = frame_q[3];
        end
      end
    end else begin
      pos_d = pos_q + 1'b1;
    end
    rel_ext       = EXT_W'(relay_d);
    desc_o.relays = rel_ext[LEVEL_BITS-1:0];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      lock_q  <= '0;
      relay_q <= '0;
      mark_q  <= '1;
    end else if (accept) begin
      pos_q   <= pos_d;
      lock_q  <= lock_d;
      relay_q <= relay_d;
      mark_q  <= mark_d;
    end
  end

  // Frame bytes, written at the current position
  always_ff @(posedge clk_i) begin
    if (accept && !opcode_i) begin
      frame_q[pos_q] <= rx_byte_i;
    end
  end

endmodule

>>> sv/srsc_queue.sv
// ---------------------------------------------------------------------------
// srsc_queue
// Small FIFO of message descriptors between the front end and the
// transmit side.
// ---------------------------------------------------------------------------
module srsc_queue import srsc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  srsc_desc_t push_data_i,
  output logic       full_n_o,
  output logic       pop_valid_o,
  input  logic       pop_i,
  output srsc_desc_t pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  srsc_desc_t       mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_pop;

  assign full_n_o    = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_q];
  assign do_pop      = pop_i & pop_valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/srsc_back.sv
// ---------------------------------------------------------------------------
// srsc_back
// Turns each descriptor into one idle result or four message bytes, one
// result per cycle unless the receiver stalls, through an output register.
// ---------------------------------------------------------------------------
module srsc_back import srsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  desc_valid_i,
  output logic                  desc_pop_o,
  input  srsc_desc_t            desc_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  tx_valid_o,
  output logic [7:0]            tx_byte_o,
  output logic                  last_o,
  output logic [LEVEL_BITS-1:0] relay_levels_o
);

  logic                  out_valid_q;
  logic                  tx_valid_q;
  logic [7:0]            tx_byte_q;
  logic                  last_q;
  logic [LEVEL_BITS-1:0] relays_q;
  logic [1:0]            cnt_q;
  logic                  load, emit, is_last;

  assign load       = !out_valid_q || out_ready_i;
  assign emit       = load && desc_valid_i;
  assign is_last    = !desc_i.has_msg || (cnt_q == 2'd3);
  assign desc_pop_o = emit && is_last;

  // Byte counter within a message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        cnt_q       <= is_last ? 2'd0 : cnt_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (load) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      tx_valid_q <= desc_i.has_msg;
      tx_byte_q  <= desc_i.has_msg ? desc_i.text[cnt_q] : 8'h00;
      last_q     <= is_last;
      relays_q   <= desc_i.relays;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tx_valid_o     = tx_valid_q;
  assign tx_byte_o      = tx_byte_q;
  assign last_o         = last_q;
  assign relay_levels_o = relays_q;

endmodule

>>> sv/serial_relay_switch_controller.sv
// ---------------------------------------------------------------------------
// serial_relay_switch_controller
// Relay controller driven by serial frames and wall-switch scans.
// ---------------------------------------------------------------------------
// Each input transaction is a received serial byte or a scan of the switch
// levels. The front end takes one transaction per cycle whenever its
// two-entry descriptor queue has room, updating frame, lock, relay and
// pending-change state in that same cycle. The transmit side emits one
// result per cycle while the receiver is ready: one idle result for a
// transaction without a message, four bytes (ERRX, ERLS, G ack or R
// report) otherwise. A result passes through the descriptor queue and
// then the single output register. relay_levels_o shows the relay drive
// after the transaction that caused the result.
// ---------------------------------------------------------------------------
module serial_relay_switch_controller import srsc_pkg::*; #(
  parameter int NUM_SWITCHES = SRSC_NUM_SWITCHES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [LEVEL_BITS-1:0] switch_levels_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  tx_valid_o,
  output logic [7:0]            tx_byte_o,
  output logic                  last_o,
  output logic [LEVEL_BITS-1:0] relay_levels_o
);

  logic       push, full_n, q_valid, q_pop;
  srsc_desc_t push_data, q_data;

  srsc_front #(
    .NUM_SWITCHES(NUM_SWITCHES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .rx_byte_i,
    .switch_levels_i,
    .desc_valid_o (push),
    .desc_ready_i (full_n),
    .desc_o       (push_data)
  );

  srsc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_n_o    (full_n),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  srsc_back u_back (
    .clk_i,
    .rst_ni,
    .desc_valid_i (q_valid),
    .desc_pop_o   (q_pop),
    .desc_i       (q_data),
    .out_valid_o,
    .out_ready_i,
    .tx_valid_o,
    .tx_byte_o,
    .last_o,
    .relay_levels_o
  );

endmodule

>>> sv/srsc_checker.sv
// ---------------------------------------------------------------------------
// srsc_checker
// Port-level checks of the relay controller, bound to the top level.
// ---------------------------------------------------------------------------
module srsc_checker import srsc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  tx_valid_o,
  input logic [7:0]            tx_byte_o,
  input logic                  last_o,
  input logic [LEVEL_BITS-1:0] relay_levels_o
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_byte_o) &&
    $stable(last_o) && $stable(relay_levels_o))
    else $error("result changed while stalled");

  // A result without a byte is the whole answer and carries zero
  a_idle_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> last_o && (tx_byte_o == 8'h00))
    else $error("idle result not alone or not zero");

  // Bytes of one message follow back to back with one relay snapshot
  a_msg_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o && tx_valid_o &&
    $stable(relay_levels_o))
    else $error("message bytes not contiguous");

  // A message never ends on its first byte: a result accepted just
  // before a final message byte is an earlier byte of the same message
  a_msg_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && tx_valid_o && last_o &&
    $past(out_valid_o && out_ready_i) |->
    $past(tx_valid_o) && !$past(last_o))
    else $error("message shorter than two bytes");

endmodule

bind serial_relay_switch_controller srsc_checker u_srsc_checker (.*);

>>> dv/serial_relay_switch_controller_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// serial_relay_switch_controller_tb
// Self-checking bench for the serial relay switch controller.
// ---------------------------------------------------------------------------
// A directed table covers the following cases:
//   - scans right after reset
//   - bad first bytes at the byte extremes
//   - one acknowledged frame that locks switch 11
//   - reports with both levels
// The random part is made of whole frames with random content:
//   - some frames are broken and some have scans mixed in
//   - stray bytes and scans with random levels come between them
// A predictor in the bench tracks the frame, lock, relay and pending-change
// state, and queues the expected results of every accepted transaction.
// Each result is checked field by field against the oldest expectation.
// Idling on both sides changes from phase to phase, and in one phase the
// receiver holds off long enough to stall the input.
// ---------------------------------------------------------------------------
module serial_relay_switch_controller_tb;
  import srsc_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_SCAN = 1'b1;

  localparam int unsigned MAX_GAP      = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  // How a directed row is checked: by the predictor, or by a typed answer
  typedef enum logic [1:0] {
    CHK_PRED,
    CHK_IDLE,
    CHK_MSG
  } row_chk_e;

  typedef struct packed {
    logic                  op;
    logic [7:0]            rx;
    logic [LEVEL_BITS-1:0] lv;
    row_chk_e              chk;
    logic [31:0]           txt;
  } stim_row_t;

  typedef struct packed {
    logic                  tx_valid;
    logic [7:0]            tx_byte;
    logic                  last;
    logic [LEVEL_BITS-1:0] relays;
  } reply_t;

  // DUT connections
  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic                  opcode_i        = OP_BYTE;
  logic [7:0]            rx_byte_i       = '0;
  logic [LEVEL_BITS-1:0] switch_levels_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic                  tx_valid_o;
  logic [7:0]            tx_byte_o;
  logic                  last_o;
  logic [LEVEL_BITS-1:0] relay_levels_o;

  // Predicted controller state
  logic [7:0]            frm_buf [FRAME_BYTES];
  logic [POS_W-1:0]      frm_pos  = '0;
  logic [LEVEL_BITS-1:0] sw_lock  = '0;
  logic [LEVEL_BITS-1:0] sw_relay = '0;
  logic [LEVEL_BITS-1:0] sw_mark  = '1;

  reply_t      reply_q [$];
  reply_t      head_reply;
  stim_row_t   dir_rows [$];
  int unsigned err_cnt       = 0;
  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_cnt      = 0;
  bit          hold_req      = 1'b0;

  serial_relay_switch_controller uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .rx_byte_i      (rx_byte_i),
    .switch_levels_i(switch_levels_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tx_valid_o     (tx_valid_o),
    .tx_byte_o      (tx_byte_o),
    .last_o         (last_o),
    .relay_levels_o (relay_levels_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #1ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Advance the predicted state by one transaction and give its message, if any
  function automatic void predict_reply(input logic op, input logic [7:0] rx,
                                        input logic [LEVEL_BITS-1:0] lv,
                                        output logic has_msg, output logic [31:0] txt);
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  st;
    int unsigned num;
    int unsigned i;
    logic        hit;
    has_msg = 1'b0;
    txt     = '0;
    hit     = 1'b0;
    if (op == OP_BYTE) begin
      frm_buf[frm_pos] = rx;
      if (frm_buf[0] != CH_PCT) begin
        frm_pos = '0;
        has_msg = 1'b1;
        txt     = {CH_E, CH_R, CH_R, CH_X};
      end else if (frm_pos != FRAME_LAST) begin
        frm_pos = frm_pos + 1'b1;
      end else begin
        frm_pos = '0;
        if (frm_buf[1] != CH_PCT || frm_buf[14] != CH_AT || frm_buf[15] != CH_AT) begin
          has_msg = 1'b1;
          txt     = {CH_E, CH_R, CH_L, CH_S};
        end else begin
          hi  = frm_buf[2];
          lo  = frm_buf[3];
          st  = frm_buf[4];
          num = 0;
          // leading decimal digits pick the switch
          if (hi >= CH_ZERO && hi <= CH_NINE) begin
            num = hi - CH_ZERO;
            if (lo >= CH_ZERO && lo <= CH_NINE) num = num * 10 + (lo - CH_ZERO);
          end
          if (num >= 1 && num <= SRSC_NUM_SWITCHES) begin
            sw_lock[num-1]  = (frm_buf[7] != CH_ZERO);
            sw_relay[num-1] = st[0];
          end
          if (frm_buf[8] == CH_ONE) begin
            has_msg = 1'b1;
            txt     = {CH_G, st, hi, lo};
          end
        end
      end
    end else begin
      // lowest unlocked switch whose level matches its pending mark
      for (i = 0; i < SRSC_NUM_SWITCHES; i++) begin
        if (!hit && !sw_lock[i] && lv[i] == sw_mark[i]) begin
          hit         = 1'b1;
          sw_mark[i]  = ~lv[i];
          sw_relay[i] = lv[i];
          has_msg     = 1'b1;
          txt         = {CH_R, CH_ZERO + 8'(lv[i]), CH_ZERO + 8'((i + 1) / 10),
                         CH_ZERO + 8'((i + 1) % 10)};
        end
      end
    end
  endfunction

  // Offer one transaction, wait for acceptance, queue its results
  task automatic send_item(input logic op, input logic [7:0] rx,
                           input logic [LEVEL_BITS-1:0] lv, input row_chk_e chk,
                           input logic [31:0] typed_txt);
    int unsigned gap;
    int unsigned k;
    logic        has_msg;
    logic [31:0] txt;
    reply_t      r;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    rx_byte_i       <= rx;
    switch_levels_i <= lv;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    predict_reply(op, rx, lv, has_msg, txt);
    if (chk == CHK_IDLE) begin
      has_msg = 1'b0;
    end else if (chk == CHK_MSG) begin
      has_msg = 1'b1;
      txt     = typed_txt;
    end
    r.relays = sw_relay;
    if (has_msg) begin
      for (k = 0; k < MSG_BYTES; k++) begin
        r.tx_valid = 1'b1;
        r.tx_byte  = txt[31 - 8 * k -: 8];
        r.last     = (k == MSG_BYTES - 1);
        reply_q.push_back(r);
      end
    end else begin
      r.tx_valid = 1'b0;
      r.tx_byte  = '0;
      r.last     = 1'b1;
      reply_q.push_back(r);
    end
  endtask

  task automatic send_scan();
    send_item(OP_SCAN, 8'($urandom), LEVEL_BITS'($urandom), CHK_PRED, '0);
  endtask

  // One random sequence: mostly frames, some broken, plus noise and scans
  task automatic send_random_seq();
    logic [7:0]  fr [FRAME_BYTES];
    int unsigned kind;
    int unsigned num;
    int unsigned k;
    kind = $urandom_range(99);
    if (kind < 65) begin
      fr[0] = CH_PCT;
      fr[1] = CH_PCT;
      if ($urandom_range(3) != 0) begin
        num   = $urandom_range(13);
        fr[2] = CH_ZERO + 8'(num / 10);
        fr[3] = CH_ZERO + 8'(num % 10);
      end else begin
        fr[2] = 8'($urandom);
        fr[3] = 8'($urandom);
      end
      fr[4] = $urandom_range(3) != 0 ? ($urandom_range(1) ? CH_ONE : CH_ZERO)
                                     : 8'($urandom);
      for (k = 5; k < 14; k++) fr[k] = 8'($urandom);
      fr[7]  = $urandom_range(99) < 60 ? CH_ZERO : 8'($urandom);
      fr[8]  = $urandom_range(99) < 70 ? CH_ONE : 8'($urandom);
      fr[14] = CH_AT;
      fr[15] = CH_AT;
      // broken frame: spoil one of the marker bytes
      if (kind >= 55) begin
        case ($urandom_range(2))
          0:       fr[1]  = fr[1]  ^ 8'($urandom_range(255, 1));
          1:       fr[14] = fr[14] ^ 8'($urandom_range(255, 1));
          default: fr[15] = fr[15] ^ 8'($urandom_range(255, 1));
        endcase
      end
      for (k = 0; k < FRAME_BYTES; k++) begin
        if ($urandom_range(9) == 0) send_scan();
        send_item(OP_BYTE, fr[k], LEVEL_BITS'($urandom), CHK_PRED, '0);
      end
    end else if (kind < 75) begin
      send_item(OP_BYTE, 8'($urandom), LEVEL_BITS'($urandom), CHK_PRED, '0);
    end else begin
      send_scan();
    end
  endtask

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned n_items, input bit hold);
    int unsigned stop_at;
    send_idle_pct = idle;
    stall_pct     = stall;
    if (hold) hold_req = 1'b1;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_seq();
  endtask

  function automatic stim_row_t dir_row(input logic op, input logic [7:0] rx,
                                        input logic [LEVEL_BITS-1:0] lv,
                                        input row_chk_e chk, input logic [31:0] txt);
    stim_row_t row;
    row.op  = op;
    row.rx  = rx;
    row.lv  = lv;
    row.chk = chk;
    row.txt = txt;
    return row;
  endfunction

  // Receiver: random stalls, or a long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_q.size() == 0) begin
        flag_mismatch("result with nothing expected", tx_byte_o, 0);
      end else begin
        head_reply = reply_q.pop_front();
        if (tx_valid_o !== head_reply.tx_valid)
          flag_mismatch("tx_valid", tx_valid_o, head_reply.tx_valid);
        if (tx_byte_o !== head_reply.tx_byte)
          flag_mismatch("tx_byte", tx_byte_o, head_reply.tx_byte);
        if (last_o !== head_reply.last)
          flag_mismatch("last", last_o, head_reply.last);
        if (relay_levels_o !== head_reply.relays)
          flag_mismatch("relay_levels", relay_levels_o, head_reply.relays);
      end
    end
  end

  initial begin
    logic [7:0]  ack_frame [FRAME_BYTES];
    int unsigned k;
    // switch 11 on and locked, ack requested; dimmer bytes at the extremes
    ack_frame = '{CH_PCT, CH_PCT, CH_ONE, CH_ONE, CH_ONE, 8'h00, 8'hFF, CH_ONE,
                  CH_ONE, 8'h55, 8'hAA, 8'h7F, 8'h80, 8'h20, CH_AT, CH_AT};

    // Directed table
    dir_rows.push_back(dir_row(OP_SCAN, 8'h00, 11'h000, CHK_IDLE, '0));
    dir_rows.push_back(dir_row(OP_SCAN, 8'hFF, 11'h7FF, CHK_MSG,
                               {CH_R, CH_ONE, CH_ZERO, CH_ONE}));
    dir_rows.push_back(dir_row(OP_BYTE, 8'h41, 11'h7FF, CHK_MSG,
                               {CH_E, CH_R, CH_R, CH_X}));
    dir_rows.push_back(dir_row(OP_BYTE, 8'hFF, 11'h000, CHK_MSG,
                               {CH_E, CH_R, CH_R, CH_X}));
    dir_rows.push_back(dir_row(OP_BYTE, 8'h00, 11'h7FF, CHK_MSG,
                               {CH_E, CH_R, CH_R, CH_X}));
    for (k = 0; k < FRAME_BYTES - 1; k++)
      dir_rows.push_back(dir_row(OP_BYTE, ack_frame[k], 11'h000, CHK_IDLE, '0));
    dir_rows.push_back(dir_row(OP_BYTE, ack_frame[FRAME_BYTES-1], 11'h000, CHK_MSG,
                               {CH_G, CH_ONE, CH_ONE, CH_ONE}));
    dir_rows.push_back(dir_row(OP_SCAN, 8'h00, 11'h7FF, CHK_MSG,
                               {CH_R, CH_ONE, CH_ZERO, 8'h32}));
    dir_rows.push_back(dir_row(OP_SCAN, 8'hFF, 11'h000, CHK_MSG,
                               {CH_R, CH_ZERO, CH_ZERO, CH_ONE}));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < dir_rows.size(); k++)
      send_item(dir_rows[k].op, dir_rows[k].rx, dir_rows[k].lv, dir_rows[k].chk,
                dir_rows[k].txt);

    // Random phases
    run_phase(0, 0, 12, 1'b0);
    run_phase(84, 0, 12, 1'b0);
    run_phase(0, 84, 12, 1'b0);
    run_phase(33, 33, 12, 1'b0);
    run_phase(0, 0, 10, 1'b1);

    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
